// File: src/ssc_pkg.sv
// shared types, constants and helpers for the substring search counter
package ssc_pkg;

   // fixed widths of the register file and of the result fields
   localparam int TEXT_BITS      = 8;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_BITS = 3;
   localparam int PATTERN_REGS   = 4;
   localparam int PATTERN_BYTES  = PATTERN_REGS * CSR_DATA_BITS / TEXT_BITS;
   localparam int LENGTH_BITS    = 6;
   localparam int RESULT_BITS    = 16;
   localparam int QUEUE_DEPTH    = 2;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LO     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_MID_LO = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_MID_HI = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HI     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOLD_CASE      = 3'd5;

   // configuration as seen by the match engine
   typedef struct packed {
      logic [PATTERN_BYTES-1:0][TEXT_BITS-1:0] pattern;
      logic [LENGTH_BITS-1:0]                  length;
      logic                                    fold_case;
   } cfg_type;

   // classified item passed from the front to the back
   typedef struct packed {
      logic [TEXT_BITS-1:0] text_byte;
      logic                 has_byte;
      logic                 is_end;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic                   match_found;
      logic [RESULT_BITS-1:0] first_start;
      logic [RESULT_BITS-1:0] last_start;
      logic [RESULT_BITS-1:0] match_total;
      logic                   length_overflow;
   } rsp_type;

   // ascii upper case letters map to lower case when folding is on
   function automatic logic [TEXT_BITS-1:0] fold_byte(input logic [TEXT_BITS-1:0] c,
                                                      input logic            fold_on);
      logic [TEXT_BITS-1:0] res;
      res = c;
      if (fold_on && (c inside {[8'h41:8'h5A]})) begin
         res = c | 8'h20;
      end
      return res;
   endfunction

endpackage

// File: src/substring_search_counter_core.sv
// top level: configuration registers, front, item queue, match engine, result queue
//
//   channel  ports                                        accepted when
//   request  req_push, req_full, req_text_byte, ...       req_push && !req_full
//   result   rsp_empty, rsp_pop, rsp_match_found, ...     rsp_pop && !rsp_empty
//   config   csr_we, csr_index, csr_wdata                 csr_we
//
// one item per cycle sustained while no end item waits on a full result queue; the
// window compare and counter update happen as the match engine takes each item, so
// a result item reaches the result ports through the item queue register and then
// the result queue, which the engine writes.
// reset is synchronous and clears both queues, the running state and registers.
// a pending end item stalls the engine only while the result queue is full;
// req_full then rises once the two-entry item queue fills up.
module substring_search_counter_core #(
   parameter int PATTERN_MAX   = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [ssc_pkg::TEXT_BITS-1:0]       req_text_byte,
   input  logic                                req_byte_present,
   input  logic                                req_end_of_text,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_match_found,
   output logic [ssc_pkg::RESULT_BITS-1:0]     rsp_first_start,
   output logic [ssc_pkg::RESULT_BITS-1:0]     rsp_last_start,
   output logic [ssc_pkg::RESULT_BITS-1:0]     rsp_match_total,
   output logic                                rsp_length_overflow,
   input  logic                                csr_we,
   input  logic [ssc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ssc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import ssc_pkg::*;

   logic [PATTERN_REGS-1:0][CSR_DATA_BITS-1:0] pattern_ff;
   logic [LENGTH_BITS-1:0]                     length_ff;
   logic                                       fold_ff;
   cfg_type                                    cfg;

   logic    cmd_full, cmd_push, cmd_empty, cmd_take;
   cmd_type cmd_in, cmd_out;
   logic    rsp_full, rsp_push;
   rsp_type rsp_in, rsp_out;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
         fold_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LO:     pattern_ff[0] <= csr_wdata;
            CSR_PATTERN_MID_LO: pattern_ff[1] <= csr_wdata;
            CSR_PATTERN_MID_HI: pattern_ff[2] <= csr_wdata;
            CSR_PATTERN_HI:     pattern_ff[3] <= csr_wdata;
            CSR_PATTERN_LENGTH: length_ff     <= csr_wdata[LENGTH_BITS-1:0];
            CSR_FOLD_CASE:      fold_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.pattern   = pattern_ff;
   assign cfg.length    = length_ff;
   assign cfg.fold_case = fold_ff;

   // input side
   ssc_front u_front (
      .req_push         (req_push),
      .req_text_byte    (req_text_byte),
      .req_byte_present (req_byte_present),
      .req_end_of_text  (req_end_of_text),
      .req_full         (req_full),
      .queue_full       (cmd_full),
      .queue_push       (cmd_push),
      .queue_cmd        (cmd_in)
   );

   // queue between front and engine
   ssc_queue #(
      .item_type (cmd_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_item (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_take),
      .pop_item  (cmd_out),
      .empty     (cmd_empty)
   );

   // match engine
   ssc_back #(
      .PATTERN_MAX   (PATTERN_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_out),
      .cmd_take  (cmd_take),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_in)
   );

   // result queue
   ssc_queue #(
      .item_type (rsp_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_out),
      .empty     (rsp_empty)
   );

   assign rsp_match_found     = rsp_out.match_found;
   assign rsp_first_start     = rsp_out.first_start;
   assign rsp_last_start      = rsp_out.last_start;
   assign rsp_match_total     = rsp_out.match_total;
   assign rsp_length_overflow = rsp_out.length_overflow;

endmodule

// File: src/ssc_queue.sv
// small register queue with push/full and pop/empty sides
module ssc_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/ssc_front.sv
// input side: accepts items and drops those that carry neither byte nor end
module ssc_front (
   input  logic                      req_push,
   input  logic [ssc_pkg::TEXT_BITS-1:0] req_text_byte,
   input  logic                      req_byte_present,
   input  logic                      req_end_of_text,
   output logic                      req_full,
   input  logic                      queue_full,
   output logic                      queue_push,
   output ssc_pkg::cmd_type          queue_cmd
);
   import ssc_pkg::*;

   logic accepted;

   assign req_full = queue_full;
   assign accepted = req_push && !queue_full;

   // an empty item without end changes nothing downstream
   assign queue_push = accepted && (req_byte_present || req_end_of_text);

   always_comb begin
      queue_cmd.text_byte = req_text_byte;
      queue_cmd.has_byte  = req_byte_present;
      queue_cmd.is_end    = req_end_of_text;
   end

endmodule

// File: src/ssc_back.sv
// match engine: byte window, parallel compare, positions and greedy count
module ssc_back #(
   parameter int PATTERN_MAX   = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  ssc_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   input  ssc_pkg::cmd_type cmd,
   output logic             cmd_take,
   input  logic             rsp_full,
   output logic             rsp_push,
   output ssc_pkg::rsp_type rsp_item
);
   import ssc_pkg::*;

   localparam int PB  = POSITION_BITS;
   localparam int EXT = (PB > RESULT_BITS) ? PB : RESULT_BITS;
   localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
   localparam logic [RESULT_BITS-1:0] COUNT_MAX = {RESULT_BITS{1'b1}};

   logic [TEXT_BITS-1:0]   win_ff [PATTERN_MAX];
   logic [TEXT_BITS-1:0]   win_new [PATTERN_MAX];
   logic [TEXT_BITS-1:0]   aligned [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] byte_ok;

   logic [PB-1:0]          pos_ff, pos_in, pos_new;
   logic                   ovf_ff, ovf_in, ovf_new;
   logic                   seen_ff, seen_in, seen_new;
   logic [PB-1:0]          first_ff, first_in, first_new;
   logic [PB-1:0]          last_ff, last_in, last_new;
   logic [RESULT_BITS-1:0] count_ff, count_in, count_new;
   logic [LENGTH_BITS-1:0] block_ff, block_in, block_new;

   logic [LENGTH_BITS-1:0] len;
   logic [PB-1:0]          len_ext;
   logic [PB-1:0]          start_pos;
   logic                   pos_sat;
   logic                   hit;
   logic                   do_byte;
   logic [EXT-1:0]         first_wide, last_wide;

   // an end item waits until the result queue has room
   assign cmd_take = cmd_valid && (!cmd.is_end || !rsp_full);
   assign rsp_push = cmd_take && cmd.is_end;
   assign do_byte  = cmd_take && cmd.has_byte;

   // effective pattern length, clamped to the window
   assign len     = (cfg.length > LENGTH_BITS'(PATTERN_MAX)) ?
                    LENGTH_BITS'(PATTERN_MAX) : cfg.length;
   assign len_ext = PB'(len);

   // window after taking the byte, newest first
   always_comb begin
      win_new[0] = cmd.text_byte;
      for (int j = 1; j < PATTERN_MAX; j++) begin
         win_new[j] = win_ff[j-1];
      end
   end

   // pattern reversed so that window slot j lines up with pattern byte len-1-j
   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         logic [LENGTH_BITS-1:0] src;
         src        = len - LENGTH_BITS'(1) - LENGTH_BITS'(j);
         aligned[j] = cfg.pattern[src[$clog2(PATTERN_BYTES)-1:0]];
         byte_ok[j] = (LENGTH_BITS'(j) >= len) ||
                      (fold_byte(win_new[j], cfg.fold_case) ==
                       fold_byte(aligned[j], cfg.fold_case));
      end
   end

   // position advance with saturation
   assign pos_sat   = (pos_ff == POS_MAX);
   assign pos_new   = pos_sat ? pos_ff : pos_ff + 1'b1;
   assign ovf_new   = ovf_ff || pos_sat;
   assign hit       = (len != '0) && (pos_new >= len_ext) && (&byte_ok);
   assign start_pos = pos_new - len_ext;

   // match bookkeeping for one byte
   always_comb begin
      seen_new  = seen_ff;
      first_new = first_ff;
      last_new  = last_ff;
      count_new = count_ff;
      block_new = block_ff;
      if (hit) begin
         if (!seen_ff) begin
            first_new = start_pos;
         end
         last_new = start_pos;
         seen_new = 1'b1;
         if (block_ff == '0) begin
            if (count_ff != COUNT_MAX) begin
               count_new = count_ff + 1'b1;
            end
            block_new = len - 1'b1;
         end else begin
            block_new = block_ff - 1'b1;
         end
      end else if (block_ff != '0) begin
         block_new = block_ff - 1'b1;
      end
   end

   // state after this item, before an end clears it
   always_comb begin
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      first_in = first_ff;
      last_in  = last_ff;
      count_in = count_ff;
      block_in = block_ff;
      if (do_byte) begin
         pos_in   = pos_new;
         ovf_in   = ovf_new;
         seen_in  = seen_new;
         first_in = first_new;
         last_in  = last_new;
         count_in = count_new;
         block_in = block_new;
      end
   end

   // result fields come from the updated state
   assign first_wide = EXT'(first_in);
   assign last_wide  = EXT'(last_in);

   always_comb begin
      rsp_item.match_found     = seen_in;
      rsp_item.first_start     = first_wide[RESULT_BITS-1:0];
      rsp_item.last_start      = last_wide[RESULT_BITS-1:0];
      rsp_item.match_total     = count_in;
      rsp_item.length_overflow = ovf_in;
   end

   // running state, cleared at the end of each text
   always_ff @(posedge clock) begin
      if (reset || rsp_push) begin
         pos_ff   <= '0;
         ovf_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         first_ff <= '0;
         last_ff  <= '0;
         count_ff <= '0;
         block_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         first_ff <= first_in;
         last_ff  <= last_in;
         count_ff <= count_in;
         block_ff <= block_in;
      end
   end

   // byte window; slots past the current text are never compared
   always_ff @(posedge clock) begin
      if (do_byte) begin
         for (int j = 0; j < PATTERN_MAX; j++) begin
            win_ff[j] <= win_new[j];
         end
      end
   end

endmodule

// File: src/ssc_checker.sv
// port-level checks for the substring search counter, bound to the top level
module ssc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_full,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic                               rsp_match_found,
   input logic [ssc_pkg::RESULT_BITS-1:0]    rsp_first_start,
   input logic [ssc_pkg::RESULT_BITS-1:0]    rsp_last_start,
   input logic [ssc_pkg::RESULT_BITS-1:0]    rsp_match_total,
   input logic                               rsp_length_overflow
);

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_match_found) &&
         $stable(rsp_first_start) && $stable(rsp_last_start) &&
         $stable(rsp_match_total) && $stable(rsp_length_overflow)))
      else $error("result changed while stalled");

   // no occurrence means zero positions and count
   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_match_found) |->
         (rsp_first_start == '0 && rsp_last_start == '0 && rsp_match_total == '0))
      else $error("nonzero fields without a match");

   // the first occurrence of a text is always counted
   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_match_found) |-> (rsp_match_total != '0))
      else $error("match seen but count is zero");

   // both queues come out of reset empty: no result waits and req_full is low
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

endmodule

bind substring_search_counter_core ssc_checker u_ssc_checker (.*);
